// File: rtl/core/segment_intersection_macros.svh
// Assertion macros for the segment intersection block.
// Used by rtl/core/segment_intersection.sv; no other dependencies.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef ASSERT_OFF
`define SI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/si_pkg.sv
// Shared types and constants for the segment intersection pipeline.
// No dependencies.
package si_pkg;

    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int SUM_W  = 35;
    localparam int MAG_W  = 34;
    localparam int DVD_W  = 51;
    localparam int REM_W  = 35;
    localparam int QUO_W  = 17;
    localparam int MUL_W  = 50;
    localparam int LANES  = 4;
    localparam int DIV_STAGES = QUO_W;

    localparam int LANE_PA = 0;
    localparam int LANE_PB = 1;
    localparam int LANE_CX = 2;
    localparam int LANE_CY = 3;

    localparam logic [QUO_W-1:0] PARAM_ONE = 17'h10000;

    typedef struct packed {
        logic signed [15:0] a_x1;
        logic signed [15:0] a_y1;
        logic signed [15:0] a_x2;
        logic signed [15:0] a_y2;
        logic signed [15:0] b_x1;
        logic signed [15:0] b_y1;
        logic signed [15:0] b_x2;
        logic signed [15:0] b_y2;
    } seg_in_t;

    typedef struct packed {
        logic               hit;
        logic [16:0]        param_a;
        logic [16:0]        param_b;
        logic signed [15:0] cross_x;
        logic signed [15:0] cross_y;
    } seg_out_t;

    typedef struct packed {
        logic               hit;
        logic               dax_neg;
        logic               day_neg;
        logic signed [15:0] ax1;
        logic signed [15:0] ay1;
    } si_side_t;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [QUO_W-1:0] quo_t;

endpackage

// File: rtl/core/si_front.sv
// Front pipeline: differences, products, determinant, sign fix-up, dividend forming.
// Depends on si_pkg.
module si_front
    import si_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  seg_in_t                         in_data,
    output logic                            out_valid,
    output si_side_t                        out_side,
    output mag_t                            out_det,
    output logic [LANES-1:0][DVD_W-1:0]     out_dvd
);

    // stage 1
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg, offx1_reg, offy1_reg;
    logic signed [15:0]       ax1_1_reg, ay1_1_reg;
    // stage 2
    logic                     v2_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [DIFF_W-1:0] dax2_reg, day2_reg;
    logic signed [15:0]       ax1_2_reg, ay1_2_reg;
    // stage 3
    logic                     v3_reg;
    logic signed [SUM_W-1:0]  det3_reg, na3_reg, nb3_reg;
    logic signed [DIFF_W-1:0] dax3_reg, day3_reg;
    logic signed [15:0]       ax1_3_reg, ay1_3_reg;
    // stage 4
    logic                     v4_reg;
    si_side_t                 side4_reg, side4_next;
    mag_t                     det4_reg, na4_reg, nb4_reg;
    logic [15:0]              adax4_reg, aday4_reg;
    // stage 5
    logic                     v5_reg;
    si_side_t                 side5_reg;
    mag_t                     det5_reg, na5_reg, nb5_reg;
    logic [MUL_W-1:0]         mx5_reg, my5_reg;

    logic signed [SUM_W-1:0]  det_m, na_n, nb_n;
    logic signed [DIFF_W-1:0] adax, aday;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        det_m = det3_reg[SUM_W-1] ? -det3_reg : det3_reg;
        na_n  = det3_reg[SUM_W-1] ? -na3_reg  : na3_reg;
        nb_n  = det3_reg[SUM_W-1] ? -nb3_reg  : nb3_reg;
        adax  = dax3_reg[DIFF_W-1] ? -dax3_reg : dax3_reg;
        aday  = day3_reg[DIFF_W-1] ? -day3_reg : day3_reg;
        side4_next.hit     = (det3_reg != '0) && !na_n[SUM_W-1] && !nb_n[SUM_W-1]
                             && (na_n <= det_m) && (nb_n <= det_m);
        side4_next.dax_neg = dax3_reg[DIFF_W-1];
        side4_next.day_neg = day3_reg[DIFF_W-1];
        side4_next.ax1     = ax1_3_reg;
        side4_next.ay1     = ay1_3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax1_reg  <= DIFF_W'(in_data.a_x2) - DIFF_W'(in_data.a_x1);
            day1_reg  <= DIFF_W'(in_data.a_y2) - DIFF_W'(in_data.a_y1);
            dbx1_reg  <= DIFF_W'(in_data.b_x2) - DIFF_W'(in_data.b_x1);
            dby1_reg  <= DIFF_W'(in_data.b_y2) - DIFF_W'(in_data.b_y1);
            offx1_reg <= DIFF_W'(in_data.a_x1) - DIFF_W'(in_data.b_x1);
            offy1_reg <= DIFF_W'(in_data.a_y1) - DIFF_W'(in_data.b_y1);
            ax1_1_reg <= in_data.a_x1;
            ay1_1_reg <= in_data.a_y1;

            p1_reg    <= PROD_W'(dby1_reg) * PROD_W'(dax1_reg);
            p2_reg    <= PROD_W'(dbx1_reg) * PROD_W'(day1_reg);
            p3_reg    <= PROD_W'(dbx1_reg) * PROD_W'(offy1_reg);
            p4_reg    <= PROD_W'(dby1_reg) * PROD_W'(offx1_reg);
            p5_reg    <= PROD_W'(dax1_reg) * PROD_W'(offy1_reg);
            p6_reg    <= PROD_W'(day1_reg) * PROD_W'(offx1_reg);
            dax2_reg  <= dax1_reg;
            day2_reg  <= day1_reg;
            ax1_2_reg <= ax1_1_reg;
            ay1_2_reg <= ay1_1_reg;

            det3_reg  <= SUM_W'(p1_reg) - SUM_W'(p2_reg);
            na3_reg   <= SUM_W'(p3_reg) - SUM_W'(p4_reg);
            nb3_reg   <= SUM_W'(p5_reg) - SUM_W'(p6_reg);
            dax3_reg  <= dax2_reg;
            day3_reg  <= day2_reg;
            ax1_3_reg <= ax1_2_reg;
            ay1_3_reg <= ay1_2_reg;

            side4_reg <= side4_next;
            det4_reg  <= det_m[MAG_W-1:0];
            na4_reg   <= na_n[MAG_W-1:0];
            nb4_reg   <= nb_n[MAG_W-1:0];
            adax4_reg <= adax[15:0];
            aday4_reg <= aday[15:0];

            side5_reg <= side4_reg;
            det5_reg  <= det4_reg;
            na5_reg   <= na4_reg;
            nb5_reg   <= nb4_reg;
            mx5_reg   <= MUL_W'(na4_reg) * MUL_W'(adax4_reg);
            my5_reg   <= MUL_W'(na4_reg) * MUL_W'(aday4_reg);
        end
    end

    assign out_valid        = v5_reg;
    assign out_side         = side5_reg;
    assign out_det          = det5_reg;
    assign out_dvd[LANE_PA] = {1'b0, na5_reg, 16'h0000};
    assign out_dvd[LANE_PB] = {1'b0, nb5_reg, 16'h0000};
    assign out_dvd[LANE_CX] = {1'b0, mx5_reg};
    assign out_dvd[LANE_CY] = {1'b0, my5_reg};

endmodule

// File: rtl/core/si_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// Depends on si_pkg.
module si_div
    import si_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  si_side_t                        in_side,
    input  mag_t                            in_det,
    input  logic [LANES-1:0][DVD_W-1:0]     in_dvd,
    output logic                            out_valid,
    output si_side_t                        out_side,
    output logic [LANES-1:0][QUO_W-1:0]     out_quo,
    output logic [LANES-1:0]                out_rem_nz
);

    logic             v_reg    [DIV_STAGES];
    si_side_t         side_reg [DIV_STAGES];
    mag_t             det_reg  [DIV_STAGES];
    mag_t             rem_reg  [DIV_STAGES][LANES];
    quo_t             quo_reg  [DIV_STAGES][LANES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES][LANES];

    mag_t             rem_next [DIV_STAGES][LANES];
    quo_t             quo_next [DIV_STAGES][LANES];

    always_comb
    begin
        mag_t             r_src;
        quo_t             q_src;
        logic [QUO_W-1:0] l_src;
        mag_t             d_src;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] d;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                begin
                    r_src = in_dvd[l][DVD_W-1:QUO_W];
                    q_src = '0;
                    l_src = in_dvd[l][QUO_W-1:0];
                    d_src = in_det;
                end
                else
                begin
                    r_src = rem_reg[s-1][l];
                    q_src = quo_reg[s-1][l];
                    l_src = low_reg[s-1][l];
                    d_src = det_reg[s-1];
                end
                t = {r_src, l_src[QUO_W-1-s]};
                d = t - {1'b0, d_src};
                q_src[QUO_W-1-s] = !d[REM_W-1];
                rem_next[s][l] = d[REM_W-1] ? t[MAG_W-1:0] : d[MAG_W-1:0];
                quo_next[s][l] = q_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            det_reg[0]  <= in_det;
            for (int l = 0; l < LANES; l++)
            begin
                low_reg[0][l] <= in_dvd[l][QUO_W-1:0];
            end
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                det_reg[s]  <= det_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    low_reg[s][l] <= low_reg[s-1][l];
                end
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    quo_reg[s][l] <= quo_next[s][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l]    = quo_reg[DIV_STAGES-1][l];
            out_rem_nz[l] = (rem_reg[DIV_STAGES-1][l] != '0);
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// File: rtl/core/segment_intersection.sv
// Segment intersection top level: front pipeline, divider, output register.
// Depends on si_pkg, si_front, si_div and segment_intersection_macros.svh.
//
// Tests two 2-D segments given in signed Q12.4 and returns one result per query:
// hit flag, the two segment parameters in unsigned Q1.16 and the crossing point
// in Q12.4 truncated toward zero; all fields are zero on a miss or when the
// segments are parallel. One transaction is accepted every cycle while the
// result is not stalled. The pipeline is made of five front stages (differences,
// products, determinant, sign fix-up, dividend products), a 17-stage restoring
// divider that resolves one quotient bit per stage in four lanes, and the output
// register. When the result is stalled the whole pipeline holds.
`include "segment_intersection_macros.svh"

module segment_intersection
    import si_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     query_valid,
    output logic     query_stall,
    input  seg_in_t  query,
    output logic     result_valid,
    input  logic     result_stall,
    output seg_out_t result
);

    logic                         en;
    logic                         front_valid;
    si_side_t                     front_side;
    mag_t                         front_det;
    logic [LANES-1:0][DVD_W-1:0]  front_dvd;
    logic                         div_valid;
    si_side_t                     div_side;
    logic [LANES-1:0][QUO_W-1:0]  div_quo;
    logic [LANES-1:0]             div_rem_nz;

    logic                         out_valid_reg;
    seg_out_t                     out_reg, out_next;
    logic signed [18:0]           tx, ty, cx, cy;

    assign en          = !(out_valid_reg && result_stall);
    assign query_stall = !en;

    si_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query_valid),
        .in_data   (query),
        .out_valid (front_valid),
        .out_side  (front_side),
        .out_det   (front_det),
        .out_dvd   (front_dvd)
    );

    si_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (front_valid),
        .in_side    (front_side),
        .in_det     (front_det),
        .in_dvd     (front_dvd),
        .out_valid  (div_valid),
        .out_side   (div_side),
        .out_quo    (div_quo),
        .out_rem_nz (div_rem_nz)
    );

    // floor quotient rebuilt from magnitude division, then truncated toward zero
    always_comb
    begin
        if (div_side.dax_neg)
        begin
            tx = 19'(div_side.ax1) - 19'(div_quo[LANE_CX]) - 19'(div_rem_nz[LANE_CX]);
        end
        else
        begin
            tx = 19'(div_side.ax1) + 19'(div_quo[LANE_CX]);
        end
        if (div_side.day_neg)
        begin
            ty = 19'(div_side.ay1) - 19'(div_quo[LANE_CY]) - 19'(div_rem_nz[LANE_CY]);
        end
        else
        begin
            ty = 19'(div_side.ay1) + 19'(div_quo[LANE_CY]);
        end
        cx = tx + 19'(div_rem_nz[LANE_CX] && tx[18]);
        cy = ty + 19'(div_rem_nz[LANE_CY] && ty[18]);

        out_next = '0;
        if (div_side.hit)
        begin
            out_next.hit     = 1'b1;
            out_next.param_a = div_quo[LANE_PA];
            out_next.param_b = div_quo[LANE_PB];
            out_next.cross_x = cx[15:0];
            out_next.cross_y = cy[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SI_ASSERT_IMP(a_miss_zero, clk, rst_n, result_valid && !result.hit, result.param_a == '0 && result.param_b == '0 && result.cross_x == '0 && result.cross_y == '0, "miss result carries nonzero fields")
    `SI_ASSERT_IMP(a_param_range, clk, rst_n, result_valid && result.hit, result.param_a <= PARAM_ONE && result.param_b <= PARAM_ONE, "segment parameter above one")
    `SI_ASSERT_IMP(a_no_backpressure, clk, rst_n, !result_stall, !query_stall, "query stalled while result side is free")
    `SI_ASSERT_NXT(a_drain, clk, rst_n, result_valid && !result_stall && !div_valid, !result_valid, "result repeated after transaction")

endmodule
